@@ sv/brc_pkg.sv @@
// shared types and constants of the block request coalescer
package brc_pkg;

  localparam int ID_W       = 6;
  localparam int LEN_W      = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_BLOCK   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  localparam logic STATUS_ISSUED  = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLES = 1'b1;

  localparam logic [CFG_DATA_W-1:0] MAX_CHUNK_RST = 16'd16;
  localparam logic [CFG_DATA_W-1:0] MAX_HOLES_RST = 16'd4;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic            refill;
    logic [ID_W-1:0] push_id;
  } fl_req_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] head_id;
  } fl_stat_t;

endpackage

@@ sv/brc_free_list.sv @@
// fifo free list of chunk ids, ring memory with fill tracking instead of a clearing pass
module brc_free_list import brc_pkg::*; #(
  parameter int ID_COUNT = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  fl_req_t  req,
  output fl_stat_t stat
);

  localparam int IW   = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int CNTW = $clog2(ID_COUNT + 1);
  localparam logic [IW-1:0]   LAST_IDX = IW'(ID_COUNT - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(ID_COUNT);

  logic [ID_W-1:0] mem [ID_COUNT];

  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic [ID_W-1:0] rd_q_r;
  logic            byp_r;
  logic [ID_W-1:0] byp_id_r;

  logic                 full;
  logic                 push_ok;
  logic                 head_written;
  logic [IW+ID_W-1:0]   ident_w;

  assign full    = (count_r == FULL_CNT);
  assign push_ok = req.push && !full;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    wrapped_nxt = wrapped_r;
    if (req.refill) begin
      head_nxt    = '0;
      tail_nxt    = '0;
      count_nxt   = FULL_CNT;
      wrapped_nxt = 1'b0;
    end else if (push_ok) begin
      tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
      if (tail_r == LAST_IDX) begin
        wrapped_nxt = 1'b1;
      end
    end else if (req.pop) begin
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= FULL_CNT;
      wrapped_r <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      wrapped_r <= wrapped_nxt;
      byp_r     <= push_ok && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= req.push_id;
    end
    rd_q_r   <= mem[head_nxt];
    byp_id_r <= req.push_id;
  end

  // entries below the tail were written since the last refill, the rest hold their index
  assign head_written = wrapped_r || (head_r < tail_r);
  assign ident_w      = {{ID_W{1'b0}}, head_r};

  assign stat.empty   = (count_r == '0);
  assign stat.full    = full;
  assign stat.head_id = head_written ? (byp_r ? byp_id_r : rd_q_r) : ident_w[ID_W-1:0];

endmodule

@@ sv/brc_scan.sv @@
// scan state and per-item chunk decisions, up to two results per block transaction
module brc_scan import brc_pkg::*; #(
  parameter int BATCH_SIZE       = 32,
  parameter int BLOCK_INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  kind_t                     kind,
  input  logic                      req,
  input  logic                      last,
  input  logic [ID_W-1:0]           chunk_to_free,
  input  logic [CFG_DATA_W-1:0]     max_chunk_blocks,
  input  logic [CFG_DATA_W-1:0]     max_holes,
  input  fl_stat_t                  fl_stat,
  output fl_req_t                   fl_req,
  output logic [1:0]                res_cnt,
  output logic [BLOCK_INDEX_BITS+ID_W+LEN_W+2:0] res0,
  output logic [BLOCK_INDEX_BITS+ID_W+LEN_W+2:0] res1
);

  localparam int B     = BLOCK_INDEX_BITS;
  localparam int RES_W = B + ID_W + LEN_W + 3;
  localparam int CW    = (B > LEN_W) ? B : LEN_W;
  localparam int BW    = $clog2(BATCH_SIZE + 1);
  localparam logic [BW-1:0] BATCH_FULL = BW'(BATCH_SIZE);

  logic [B-1:0]     pos_r, pos_nxt;
  logic             open_r, open_nxt;
  logic [B-1:0]     start_r, start_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] holes_r, holes_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [BW-1:0]    fill_r, fill_nxt;

  logic [B-1:0]     pos_inc;
  logic [CW-1:0]    span_w;
  logic [LEN_W-1:0] limit;
  logic             over;
  logic [LEN_W-1:0] holes_inc;
  logic [BW-1:0]    fill_inc;
  logic             bend1;

  logic             is_block;
  logic             try_open;
  logic             close_a;
  logic             drop;
  logic             open_new;
  logic             open_after;
  logic             close_f;
  logic [LEN_W-1:0] len_upd;
  logic [ID_W-1:0]  fin_id;
  logic [B-1:0]     fin_start;
  logic [LEN_W-1:0] fin_len;
  logic [RES_W-1:0] res_a, res_d, res_f;

  function automatic logic [RES_W-1:0] pack_res(
    input logic status, input logic [ID_W-1:0] id, input logic [B-1:0] start,
    input logic [LEN_W-1:0] len, input logic bend, input logic lst
  );
    pack_res = {lst, status, bend, len, start, id};
  endfunction

  assign pos_inc   = pos_r + 1'b1;
  assign span_w    = CW'(pos_inc - start_r);
  assign limit     = (max_chunk_blocks == '0) ? LEN_W'(1) : max_chunk_blocks;
  assign over      = span_w > CW'(limit);
  assign holes_inc = (holes_r == '1) ? holes_r : holes_r + 1'b1;
  assign fill_inc  = fill_r + 1'b1;
  assign bend1     = fill_inc >= BATCH_FULL;
  assign is_block  = (kind == KIND_BLOCK);

  always_comb begin
    try_open  = 1'b0;
    close_a   = 1'b0;
    holes_nxt = holes_r;
    len_upd   = len_r;
    if (open_r) begin
      if (over) begin
        // span limit: emit, then look at this block again as a new start
        close_a  = 1'b1;
        try_open = req;
      end else if (req) begin
        len_upd = span_w[LEN_W-1:0];
      end else begin
        holes_nxt = holes_inc;
        if ((max_holes != '0) && (holes_inc == max_holes)) begin
          close_a = 1'b1;
        end
      end
    end else begin
      try_open = req;
    end
    drop       = try_open && fl_stat.empty;
    open_new   = try_open && !fl_stat.empty;
    open_after = open_new || (open_r && !close_a);
    close_f    = last && open_after;
  end

  assign fin_id    = open_new ? fl_stat.head_id : id_r;
  assign fin_start = open_new ? pos_r : start_r;
  assign fin_len   = open_new ? LEN_W'(1) : len_upd;

  assign res_a = pack_res(STATUS_ISSUED, id_r, start_r, len_r,
                          bend1 || (last && !close_f), 1'b0);
  assign res_d = pack_res(STATUS_DROPPED, '0, pos_r, '0, 1'b0, 1'b0);
  assign res_f = pack_res(STATUS_ISSUED, fin_id, fin_start, fin_len, 1'b1, 1'b0);

  always_comb begin
    res_cnt = '0;
    if (fire && is_block) begin
      res_cnt = 2'({1'b0, close_a} + {1'b0, drop} + {1'b0, close_f});
    end
    res0 = close_a ? res_a : (drop ? res_d : res_f);
    res1 = drop ? res_d : res_f;
    res0[RES_W-1] = (res_cnt == 2'd1);
    res1[RES_W-1] = 1'b1;
  end

  always_comb begin
    pos_nxt   = pos_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    fill_nxt  = fill_r;
    fl_req    = '0;
    fl_req.push_id = chunk_to_free;
    if (fire) begin
      unique case (kind)
        KIND_BLOCK: begin
          pos_nxt  = pos_inc;
          open_nxt = open_after && !last;
          len_nxt  = len_upd;
          if (open_new) begin
            fl_req.pop = 1'b1;
            id_nxt     = fl_stat.head_id;
            start_nxt  = pos_r;
            len_nxt    = LEN_W'(1);
          end
          if (last) begin
            fill_nxt = '0;
          end else if (close_a) begin
            fill_nxt = bend1 ? '0 : fill_inc;
          end
        end
        KIND_RESTART: begin
          fl_req.refill = 1'b1;
          pos_nxt   = '0;
          open_nxt  = 1'b0;
          start_nxt = '0;
          len_nxt   = '0;
          fill_nxt  = '0;
        end
        KIND_RELEASE: begin
          fl_req.push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      holes_r <= '0;
      id_r    <= '0;
      fill_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      id_r    <= id_nxt;
      fill_r  <= fill_nxt;
      if (fire && kind == KIND_RESTART) begin
        holes_r <= '0;
      end else if (fire && is_block) begin
        holes_r <= open_new ? '0 : holes_nxt;
      end
    end
  end

endmodule

@@ sv/brc_out_queue.sv @@
// four-entry result queue, takes up to two results per cycle and returns one
module brc_out_queue #(
  parameter int WIDTH = 55
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] push0,
  input  logic [WIDTH-1:0] push1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] q_r [4];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [2:0]       cnt_r;
  logic             pop;
  logic [1:0]       wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  // two free slots are needed for a block transaction that may emit two results
  assign room      = (cnt_r <= 3'd2);
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + {1'b0, push_cnt} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

@@ sv/block_request_coalescer_unit.sv @@
// top level of the block request coalescer
// Takes one transaction per cycle: a block flag, a restart or a chunk id release. Each
// transaction is registered at the input and then handled against the scan state and the
// free id list; its results are written into the result queue that feeds the output port.
// A block flag yields zero, one or two results (a chunk closed by the span
// limit followed by a dropped block or a chunk closed at the last block), and the output
// port returns one result per cycle, so the sustained rate is one transaction per cycle
// except where results pile up faster than out_tready takes them. The free list is a
// ring memory with a read register; after reset or restart it reads as ids in order
// without any clearing pass. Configuration registers take effect on the next block.
module block_request_coalescer_unit import brc_pkg::*; #(
  parameter int ID_COUNT         = 64,
  parameter int BATCH_SIZE       = 32,
  parameter int BLOCK_INDEX_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // requested, chunk_to_free[5:0], zero pad
  input  logic [KIND_W-1:0]      in_tuser,   // kind
  input  logic                   in_tlast,   // last_block
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // buf_id[5:0], start_block, length_blocks[15:0], batch_end, zero pad
  output logic [((BLOCK_INDEX_BITS+23+7)/8)*8-1:0] out_tdata,
  output logic                   out_tuser,  // status
  output logic                   out_tlast,  // last_result
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int B     = BLOCK_INDEX_BITS;
  localparam int RES_W = B + ID_W + LEN_W + 3;
  localparam int OUT_W = ((B + 23 + 7) / 8) * 8;

  logic                  in_valid_r;
  kind_t                 in_kind_r;
  logic                  in_req_r;
  logic                  in_last_r;
  logic [ID_W-1:0]       in_free_r;
  logic [CFG_DATA_W-1:0] max_chunk_r;
  logic [CFG_DATA_W-1:0] max_holes_r;

  logic             fire;
  logic             room;
  fl_req_t          fl_req;
  fl_stat_t         fl_stat;
  logic [1:0]       res_cnt;
  logic [RES_W-1:0] res0, res1;
  logic [RES_W-1:0] q_data;

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      max_chunk_r <= MAX_CHUNK_RST;
      max_holes_r <= MAX_HOLES_RST;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_CHUNK: max_chunk_r <= cfg_data;
          CFG_MAX_HOLES: max_holes_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= kind_t'(in_tuser);
      in_req_r  <= in_tdata[0];
      in_last_r <= in_tlast;
      in_free_r <= in_tdata[ID_W:1];
    end
  end

  brc_free_list #(
    .ID_COUNT (ID_COUNT)
  ) u_free_list (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fl_req),
    .stat  (fl_stat)
  );

  brc_scan #(
    .BATCH_SIZE       (BATCH_SIZE),
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .kind             (in_kind_r),
    .req              (in_req_r),
    .last             (in_last_r),
    .chunk_to_free    (in_free_r),
    .max_chunk_blocks (max_chunk_r),
    .max_holes        (max_holes_r),
    .fl_stat          (fl_stat),
    .fl_req           (fl_req),
    .res_cnt          (res_cnt),
    .res0             (res0),
    .res1             (res1)
  );

  brc_out_queue #(
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = OUT_W'(q_data[RES_W-3:0]);
  assign out_tuser = q_data[RES_W-2];
  assign out_tlast = q_data[RES_W-1];

endmodule
